FILE: hdl/gcf_pkg.sv
package gcf_pkg;

  // Default geometry of the particle store
  localparam int unsigned BUCKETS_DEF          = 256;
  localparam int unsigned SLOTS_PER_BUCKET_DEF = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_K   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 2'd2;

  localparam logic [15:0] CELL_SCALE_RST = 16'd256;
  localparam logic [31:0] SPRING_K_RST   = 32'd65536;
  localparam logic [31:0] DAMPING_RST    = 32'd0;

  // Item modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNDEF  = 2'd3;

  // Cell hash multipliers
  localparam logic [31:0] HASH_PX = 32'd73856093;
  localparam logic [31:0] HASH_PY = 32'd19349663;

  // Smallest squared distance that still counts as a contact (Q32.32)
  localparam logic [63:0] SMALL_D2 = 64'd42950;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic [30:0]         radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  force_x;
    logic signed [31:0]  force_y;
    logic [6:0]          contact_count;
    logic                status;
  } out_t;

  typedef struct packed {
    logic [31:0]         cell_key;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  vel_x;
    logic signed [31:0]  vel_y;
    logic [30:0]         radius;
  } slot_t;

endpackage

FILE: hdl/grid_binned_contact_force.sv
// Cell-list contact force unit for 2-D discs in Q16.16.
// Input channel: in_valid_i / in_stall_o carry one in_t word. Mode insert bins a
// particle into the bucket of its cell (status 1 if that bucket is full), mode
// query sums the spring-dashpot force of every overlapping disc stored in the
// 3x3 neighbouring cells, mode clear empties the store, mode 3 does nothing.
// Output channel: out_valid_o / out_stall_i carry one out_t word per item.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (cell_scale, spring_k, damping). The user must write only while the unit is
// idle; the block does not enforce it. Flow: one item at a time; in_stall_o
// is high from acceptance until the result is loaded into the output register.
// A cell hash takes two multiplies and the bucket is the low hash bits (BUCKETS
// is a power of two). A query scans the stored discs of each neighbour bucket;
// a contact takes 32 root steps, 2 x 48 divide steps and 11 multiplies; a clear
// zeroes the fill count of every bucket.
// One 33x33 multiplier and one subtractor are shared by all of that work.
// Reset: a clearing pass over all buckets zeroes the bucket fill counts;
// in_stall_o stays high meanwhile, configuration writes are taken as usual.
// A stalled result waits in the output register; the next item is already
// accepted then, and its result is held back until the register is free.
module grid_binned_contact_force #(
  parameter int unsigned BUCKETS          = gcf_pkg::BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = gcf_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gcf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gcf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  gcf_pkg::in_t                     in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output gcf_pkg::out_t                    out_word_o
);
  import gcf_pkg::*;

  localparam int unsigned NSLOTS = BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned BW     = $clog2(BUCKETS);
  localparam int unsigned SW     = $clog2(NSLOTS);
  localparam int unsigned FW     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned ACC_W  = 58;
  localparam int unsigned SUB_W  = 37;

  localparam logic [FW-1:0] SPB_F    = FW'(SLOTS_PER_BUCKET);
  localparam logic [BW-1:0] BKT_LAST = BW'(BUCKETS - 1);

  localparam logic signed [65:0] I32_MAX   = 66'sd2147483647;
  localparam logic signed [65:0] I32_MIN   = -66'sd2147483648;
  localparam logic signed [65:0] FORCE_LIM = 66'sd70368744177663;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_CELL_X, ST_CELL_Y, ST_CELL_END, ST_NB,
    ST_HASH_A, ST_HASH_B, ST_HASH_C, ST_DIV, ST_DIV_END, ST_FILL, ST_BUCKET,
    ST_SLOT, ST_CHK, ST_QX, ST_QY, ST_RR, ST_TEST, ST_SQRT, ST_SQ_END,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
    ST_DONE
  } state_e;

  typedef enum logic {
    DIV_X, DIV_Y
  } div_e;

  state_e                   state_q;
  div_e                     div_sel_q;
  logic                     init_q;
  logic [15:0]              scale_q;
  logic [31:0]              spring_k_q;
  logic [31:0]              damping_q;
  in_t                      in_q;
  logic [15:0]              cx_q, cy_q;
  logic [1:0]               ox_q, oy_q;
  logic [15:0]              nb_x_q, nb_y_q;
  logic [31:0]              h1_q;
  logic [BW-1:0]            bkt_q;
  logic [BW-1:0]            clr_q;
  logic [FW-1:0]            k_q;
  logic [5:0]               cnt_q;
  logic [34:0]              rem_q;
  logic [63:0]              work_q;
  logic [47:0]              res_q;
  logic [31:0]              den_q;
  logic signed [32:0]       dx_q, dy_q;
  logic [31:0]              ax_q, ay_q;
  logic [31:0]              rsum_q;
  logic [63:0]              qx_q;
  logic [64:0]              dd_q;
  logic [31:0]              d_q;
  logic signed [17:0]       ux_q, uy_q;
  logic signed [65:0]       p_q;
  logic signed [31:0]       dot_q;
  logic [47:0]              spring_q;
  logic signed [46:0]       f_q;
  logic signed [ACC_W-1:0]  fx_q, fy_q;
  logic [6:0]               num_q;
  logic                     status_q;
  logic                     out_valid_q;
  out_t                     out_q;
  logic                     out_load;

  // Shared multiplier
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod_q;

  // Shared subtractor for root and divide steps
  logic [SUB_W-1:0]         sub_a, sub_b, sub_diff;
  logic                     sub_ge;
  logic [34:0]              rem_nx;

  // Memories
  logic [FW-1:0]            fill_mem [BUCKETS];
  logic [FW-1:0]            fill_rd_q;
  logic                     fill_we;
  logic [BW-1:0]            fill_waddr;
  logic [FW-1:0]            fill_wdata;
  slot_t                    slot_mem [NSLOTS];
  slot_t                    slot_rd_q;
  logic                     slot_we;
  logic [SW-1:0]            slot_raddr, slot_waddr;
  slot_t                    slot_wdata;

  // Per-candidate combinational terms
  logic signed [32:0]       dx_c, dy_c, rvx_c, rvy_c;
  logic [32:0]              adx_c, ady_c;
  logic [31:0]              rsum_c;
  logic [31:0]              overlap_c;
  logic [31:0]              hash_c;
  logic signed [65:0]       dot_sum_c, f_sum_c, term_c;
  logic signed [31:0]       dot_c;
  logic signed [46:0]       f_c;
  logic                     is_insert;

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'(I32_MAX);
    lo = ACC_W'(I32_MIN);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign is_insert = (in_q.mode == MODE_INSERT);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= CELL_SCALE_RST;
      spring_k_q <= SPRING_K_RST;
      damping_q  <= DAMPING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CELL_SCALE: scale_q    <= cfg_wdata_i[15:0];
        REG_SPRING_K:   spring_k_q <= cfg_wdata_i;
        REG_DAMPING:    damping_q  <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Candidate geometry
  always_comb begin
    dx_c      = 33'(slot_rd_q.pos_x) - 33'(in_q.pos_x);
    dy_c      = 33'(slot_rd_q.pos_y) - 33'(in_q.pos_y);
    adx_c     = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
    ady_c     = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
    rsum_c    = {1'b0, slot_rd_q.radius} + {1'b0, in_q.radius};
    rvx_c     = 33'(slot_rd_q.vel_x) - 33'(in_q.vel_x);
    rvy_c     = 33'(slot_rd_q.vel_y) - 33'(in_q.vel_y);
    overlap_c = rsum_q - d_q;
    hash_c    = h1_q ^ prod_q[31:0];
  end

  // Normal velocity, contact force and force term, with saturation
  always_comb begin
    dot_sum_c = (p_q + prod_q) >>> 16;
    if (dot_sum_c > I32_MAX) begin
      dot_c = 32'sh7FFFFFFF;
    end else if (dot_sum_c < I32_MIN) begin
      dot_c = 32'sh80000000;
    end else begin
      dot_c = dot_sum_c[31:0];
    end
    f_sum_c = (prod_q >>> 16) - $signed({18'b0, spring_q});
    if (f_sum_c > FORCE_LIM) begin
      f_c = FORCE_LIM[46:0];
    end else if (f_sum_c < -FORCE_LIM) begin
      f_c = 47'(-FORCE_LIM);
    end else begin
      f_c = f_sum_c[46:0];
    end
    term_c = ((p_q <<< 24) + prod_q) >>> 16;
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CELL_X: begin
        mul_a = 33'(in_q.pos_x);
        mul_b = {17'b0, scale_q};
      end
      ST_CELL_Y: begin
        mul_a = 33'(in_q.pos_y);
        mul_b = {17'b0, scale_q};
      end
      ST_HASH_A: begin
        mul_a = {17'b0, nb_x_q};
        mul_b = {1'b0, HASH_PX};
      end
      ST_HASH_B: begin
        mul_a = {17'b0, nb_y_q};
        mul_b = {1'b0, HASH_PY};
      end
      ST_QX: begin
        mul_a = {1'b0, ax_q};
        mul_b = {1'b0, ax_q};
      end
      ST_QY: begin
        mul_a = {1'b0, ay_q};
        mul_b = {1'b0, ay_q};
      end
      ST_RR: begin
        mul_a = {1'b0, rsum_q};
        mul_b = {1'b0, rsum_q};
      end
      ST_D1: begin
        mul_a = 33'(ux_q);
        mul_b = rvx_c;
      end
      ST_D2: begin
        mul_a = 33'(uy_q);
        mul_b = rvy_c;
      end
      ST_D3: begin
        mul_a = {1'b0, spring_k_q};
        mul_b = {1'b0, overlap_c};
      end
      ST_D4: begin
        mul_a = 33'(dot_q);
        mul_b = {1'b0, damping_q};
      end
      ST_F1: begin
        mul_a = 33'(ux_q);
        mul_b = 33'($signed(f_q[46:24]));
      end
      ST_F2: begin
        mul_a = 33'(ux_q);
        mul_b = {9'b0, f_q[23:0]};
      end
      ST_F3: begin
        mul_a = 33'(uy_q);
        mul_b = 33'($signed(f_q[46:24]));
      end
      ST_F4: begin
        mul_a = 33'(uy_q);
        mul_b = {9'b0, f_q[23:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Root step or divide step on the shared subtractor
  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = {1'b0, rem_q[33:0], work_q[63:62]};
      sub_b = {3'b0, res_q[31:0], 2'b01};
    end else begin
      sub_a = {4'b0, rem_q[31:0], work_q[47]};
      sub_b = {5'b0, den_q};
    end
    sub_diff = sub_a - sub_b;
    sub_ge   = ~sub_diff[SUB_W-1];
    rem_nx   = sub_ge ? sub_diff[34:0] : sub_a[34:0];
  end

  // Bucket fill counts
  always_comb begin
    fill_we    = (state_q == ST_CLR) ||
                 (state_q == ST_BUCKET && is_insert && fill_rd_q < SPB_F);
    fill_waddr = (state_q == ST_CLR) ? clr_q : bkt_q;
    fill_wdata = (state_q == ST_CLR) ? '0 : FW'(fill_rd_q + 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd_q <= fill_mem[bkt_q];
  end

  // Particle slots
  always_comb begin
    slot_raddr          = SW'(bkt_q) * SW'(SLOTS_PER_BUCKET) + SW'(k_q);
    slot_waddr          = SW'(bkt_q) * SW'(SLOTS_PER_BUCKET) + SW'(fill_rd_q);
    slot_we             = (state_q == ST_BUCKET) && is_insert && (fill_rd_q < SPB_F);
    slot_wdata.cell_key = {cy_q, cx_q};
    slot_wdata.pos_x    = in_q.pos_x;
    slot_wdata.pos_y    = in_q.pos_y;
    slot_wdata.vel_x    = in_q.vel_x;
    slot_wdata.vel_y    = in_q.vel_y;
    slot_wdata.radius   = in_q.radius;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  // Load the output register when a result is ready and the register is free
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      init_q      <= 1'b1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // hold the output word until taken, reload it from a finished item
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          if (clr_q == BKT_LAST) begin
            init_q  <= 1'b0;
            state_q <= init_q ? ST_IDLE : ST_DONE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q     <= in_word_i;
            fx_q     <= '0;
            fy_q     <= '0;
            num_q    <= '0;
            status_q <= 1'b0;
            clr_q    <= '0;
            case (in_word_i.mode)
              MODE_INSERT: state_q <= ST_CELL_X;
              MODE_QUERY:  state_q <= ST_CELL_X;
              MODE_CLEAR:  state_q <= ST_CLR;
              default:     state_q <= ST_DONE;
            endcase
          end
        end
        ST_CELL_X: state_q <= ST_CELL_Y;
        ST_CELL_Y: begin
          cx_q    <= prod_q[39:24];
          state_q <= ST_CELL_END;
        end
        ST_CELL_END: begin
          cy_q <= prod_q[39:24];
          // an insert hashes only its own cell (offset one, one)
          ox_q    <= is_insert ? 2'd1 : 2'd0;
          oy_q    <= is_insert ? 2'd1 : 2'd0;
          state_q <= ST_NB;
        end
        ST_NB: begin
          nb_x_q  <= cx_q + 16'(ox_q) + 16'hFFFF;
          nb_y_q  <= cy_q + 16'(oy_q) + 16'hFFFF;
          state_q <= ST_HASH_A;
        end
        ST_HASH_A: state_q <= ST_HASH_B;
        ST_HASH_B: begin
          h1_q    <= prod_q[31:0];
          state_q <= ST_HASH_C;
        end
        ST_HASH_C: begin
          // take the hash modulo the bucket count
          bkt_q   <= hash_c[BW-1:0];
          state_q <= ST_FILL;
        end
        ST_DIV: begin
          rem_q  <= rem_nx;
          res_q  <= {res_q[46:0], sub_ge};
          work_q <= {work_q[62:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          case (div_sel_q)
            DIV_X: begin
              ux_q      <= dx_q[32] ? -$signed(res_q[17:0]) : $signed(res_q[17:0]);
              work_q    <= {16'b0, ay_q, 16'b0};
              rem_q     <= '0;
              res_q     <= '0;
              cnt_q     <= 6'd47;
              div_sel_q <= DIV_Y;
              state_q   <= ST_DIV;
            end
            default: begin
              uy_q    <= dy_q[32] ? -$signed(res_q[17:0]) : $signed(res_q[17:0]);
              state_q <= ST_D1;
            end
          endcase
        end
        ST_FILL: state_q <= ST_BUCKET;
        ST_BUCKET: begin
          if (is_insert) begin
            status_q <= (fill_rd_q >= SPB_F);
            state_q  <= ST_DONE;
          end else begin
            k_q     <= '0;
            state_q <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          if (k_q < fill_rd_q) begin
            state_q <= ST_CHK;
          end else if (ox_q == 2'd2 && oy_q == 2'd2) begin
            state_q <= ST_DONE;
          end else begin
            // advance to the next neighbour cell
            if (oy_q == 2'd2) begin
              oy_q <= 2'd0;
              ox_q <= ox_q + 1'b1;
            end else begin
              oy_q <= oy_q + 1'b1;
            end
            state_q <= ST_NB;
          end
        end
        ST_CHK: begin
          dx_q   <= dx_c;
          dy_q   <= dy_c;
          ax_q   <= adx_c[31:0];
          ay_q   <= ady_c[31:0];
          rsum_q <= rsum_c;
          if (slot_rd_q.cell_key != {nb_y_q, nb_x_q} ||
              adx_c >= {1'b0, rsum_c} || ady_c >= {1'b0, rsum_c}) begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SLOT;
          end else begin
            state_q <= ST_QX;
          end
        end
        ST_QX: state_q <= ST_QY;
        ST_QY: begin
          qx_q    <= prod_q[63:0];
          state_q <= ST_RR;
        end
        ST_RR: begin
          dd_q    <= {1'b0, qx_q} + {1'b0, prod_q[63:0]};
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          // skip sum overflow, near coincidence and no overlap
          if (dd_q[64] || dd_q[63:0] < SMALL_D2 || dd_q[63:0] >= prod_q[63:0]) begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SLOT;
          end else begin
            work_q  <= dd_q[63:0];
            rem_q   <= '0;
            res_q   <= '0;
            cnt_q   <= 6'd31;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          rem_q  <= rem_nx;
          res_q  <= {res_q[46:0], sub_ge};
          work_q <= {work_q[61:0], 2'b00};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_SQ_END;
          end
        end
        ST_SQ_END: begin
          d_q       <= res_q[31:0];
          den_q     <= res_q[31:0];
          work_q    <= {16'b0, ax_q, 16'b0};
          rem_q     <= '0;
          res_q     <= '0;
          cnt_q     <= 6'd47;
          div_sel_q <= DIV_X;
          state_q   <= ST_DIV;
        end
        ST_D1: state_q <= ST_D2;
        ST_D2: begin
          p_q     <= prod_q;
          state_q <= ST_D3;
        end
        ST_D3: begin
          dot_q   <= dot_c;
          state_q <= ST_D4;
        end
        ST_D4: begin
          spring_q <= prod_q[63:16];
          state_q  <= ST_D5;
        end
        ST_D5: begin
          f_q     <= f_c;
          state_q <= ST_F1;
        end
        ST_F1: state_q <= ST_F2;
        ST_F2: begin
          p_q     <= prod_q;
          state_q <= ST_F3;
        end
        ST_F3: begin
          fx_q    <= fx_q + term_c[ACC_W-1:0];
          state_q <= ST_F4;
        end
        ST_F4: begin
          p_q     <= prod_q;
          state_q <= ST_F5;
        end
        ST_F5: begin
          fy_q <= fy_q + term_c[ACC_W-1:0];
          if (num_q != 7'h7F) begin
            num_q <= num_q + 1'b1;
          end
          k_q     <= k_q + 1'b1;
          state_q <= ST_SLOT;
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (out_load) begin
            out_q.force_x       <= sat_acc(fx_q);
            out_q.force_y       <= sat_acc(fy_q);
            out_q.contact_count <= num_q;
            out_q.status        <= status_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: dv/gcf_checker.sv
module gcf_checker
  import gcf_pkg::*;
#(
  parameter int unsigned BUCKETS          = BUCKETS_DEF,
  parameter int unsigned SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_word_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT     = BUCKETS * SLOTS_PER_BUCKET;
  localparam longint      FORCE_LIM = 64'sd70368744177663;
  localparam longint      I32_MIN   = -64'sd2147483648;
  localparam longint      I32_MAX   = 64'sd2147483647;

  // Shadow copy of the registers and the particle store
  logic [15:0]  scale_q;
  logic [31:0]  stiff_q;
  logic [31:0]  damp_q;
  bit           slot_used[NSLOT];
  slot_t        slot_mem[NSLOT];
  int unsigned  fill_cnt[BUCKETS];
  out_t         force_q[$];

  function automatic logic [15:0] cell_coord(logic signed [31:0] p);
    longint prod;
    prod = longint'(p) * longint'({48'b0, scale_q});
    prod = prod >>> 24;
    return prod[15:0];
  endfunction

  function automatic int unsigned bucket_idx(logic [15:0] cx, logic [15:0] cy);
    logic [31:0] h;
    h = ({16'b0, cx} * HASH_PX) ^ ({16'b0, cy} * HASH_PY);
    return h % BUCKETS;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Compute the result of one word and update the shadow store
  function automatic out_t contact_predict(in_t w);
    out_t            r;
    logic [15:0]     cx, cy, nx, ny;
    int unsigned     b, s;
    longint          dx, dy, ux, uy, rvx, rvy, dot, spring, f, fx, fy;
    longint unsigned rsum, ax, ay, qx, qy, dd, d, overlap;
    int unsigned     hits;
    r    = '0;
    fx   = 0;
    fy   = 0;
    hits = 0;
    cx   = cell_coord(w.pos_x);
    cy   = cell_coord(w.pos_y);
    case (w.mode)
      MODE_INSERT: begin
        b = bucket_idx(cx, cy);
        if (fill_cnt[b] >= SLOTS_PER_BUCKET) begin
          r.status = 1'b1;
        end else begin
          s = b * SLOTS_PER_BUCKET + fill_cnt[b];
          slot_used[s]         = 1'b1;
          slot_mem[s].cell_key = {cy, cx};
          slot_mem[s].pos_x    = w.pos_x;
          slot_mem[s].pos_y    = w.pos_y;
          slot_mem[s].vel_x    = w.vel_x;
          slot_mem[s].vel_y    = w.vel_y;
          slot_mem[s].radius   = w.radius;
          fill_cnt[b]++;
        end
      end
      MODE_QUERY: begin
        for (int ox = 0; ox < 3; ox++) begin
          for (int oy = 0; oy < 3; oy++) begin
            nx = cx + 16'(ox) - 16'd1;
            ny = cy + 16'(oy) - 16'd1;
            b  = bucket_idx(nx, ny);
            for (int k = 0; k < fill_cnt[b] && k < SLOTS_PER_BUCKET; k++) begin
              s = b * SLOTS_PER_BUCKET + k;
              if (!slot_used[s] || slot_mem[s].cell_key != {ny, nx}) continue;
              dx   = longint'(slot_mem[s].pos_x) - longint'(w.pos_x);
              dy   = longint'(slot_mem[s].pos_y) - longint'(w.pos_y);
              rsum = {33'b0, w.radius} + {33'b0, slot_mem[s].radius};
              ax   = (dx < 0) ? -dx : dx;
              ay   = (dy < 0) ? -dy : dy;
              if (ax >= rsum || ay >= rsum) continue;
              qx = ax * ax;
              qy = ay * ay;
              if (qx > ~64'd0 - qy) continue;
              dd = qx + qy;
              if (dd < SMALL_D2 || dd >= rsum * rsum) continue;
              d       = int_sqrt(dd);
              overlap = rsum - d;
              ux      = (dx * 65536) / $signed(d);
              uy      = (dy * 65536) / $signed(d);
              rvx     = longint'(slot_mem[s].vel_x) - longint'(w.vel_x);
              rvy     = longint'(slot_mem[s].vel_y) - longint'(w.vel_y);
              dot     = clip((ux * rvx + uy * rvy) >>> 16, I32_MIN, I32_MAX);
              spring  = $signed(({32'b0, stiff_q} * overlap) >> 16);
              f       = ((dot * longint'({32'b0, damp_q})) >>> 16) - spring;
              f       = clip(f, -FORCE_LIM, FORCE_LIM);
              fx      = fx + ((ux * f) >>> 16);
              fy      = fy + ((uy * f) >>> 16);
              hits++;
            end
          end
        end
        fx = clip(fx, I32_MIN, I32_MAX);
        fy = clip(fy, I32_MIN, I32_MAX);
        r.force_x       = fx[31:0];
        r.force_y       = fy[31:0];
        r.contact_count = (hits > 127) ? 7'd127 : 7'(hits);
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
        for (int i = 0; i < BUCKETS; i++) fill_cnt[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track registers, predict accepted words, compare delivered words
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      scale_q      = CELL_SCALE_RST;
      stiff_q      = SPRING_K_RST;
      damp_q       = DAMPING_RST;
      for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
      for (int i = 0; i < BUCKETS; i++) fill_cnt[i] = 0;
      force_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CELL_SCALE: scale_q = cfg_wdata_i[15:0];
          REG_SPRING_K:   stiff_q = cfg_wdata_i;
          REG_DAMPING:    damp_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) force_q = {force_q, contact_predict(in_word_i)};
      if (out_valid_i && !out_stall_i) begin
        if (force_q.size() == 0) begin
          $error("result word with no prediction waiting: %h", out_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = force_q.pop_front();
          if (out_word_i !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (out_word_i.force_x !== want.force_x)
              $error("force_x expected %0d got %0d", want.force_x, out_word_i.force_x);
            if (out_word_i.force_y !== want.force_y)
              $error("force_y expected %0d got %0d", want.force_y, out_word_i.force_y);
            if (out_word_i.contact_count !== want.contact_count)
              $error("contact_count expected %0d got %0d",
                     want.contact_count, out_word_i.contact_count);
            if (out_word_i.status !== want.status)
              $error("status expected %0d got %0d", want.status, out_word_i.status);
          end
        end
      end
      pending_o <= force_q.size();
    end
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  import gcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCH_LIMIT = 100000;
  localparam int  HOLD_CYCLES = 300;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_word;
  int                    fail_count;
  int                    pending;
  int                    sent_cnt;
  int                    cfg_cnt;
  int                    idle_cnt;
  bit                    hold_req;

  grid_binned_contact_force u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  gcf_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no word moving on either channel
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCH_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall before each word, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_t mk(logic [1:0] m, logic [31:0] px, logic [31:0] py,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] r);
    in_t w;
    w.mode   = m;
    w.pos_x  = px;
    w.pos_y  = py;
    w.vel_x  = vx;
    w.vel_y  = vy;
    w.radius = r[30:0];
    return w;
  endfunction

  // Raw Q16.16 value within +-span units of zero
  function automatic logic [31:0] near(int unsigned span);
    return $urandom_range(0, 2 * span * 65536) - span * 65536;
  endfunction

  task automatic send(in_t w);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  // Drain, let the block settle, then write all three registers
  task automatic configure(logic [15:0] sc, logic [31:0] k, logic [31:0] dmp);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_CELL_SCALE;
    cfg_wdata <= {16'b0, sc};
    @(posedge clk);
    cfg_idx   <= REG_SPRING_K;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_idx   <= REG_DAMPING;
    cfg_wdata <= dmp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_cnt++;
  endtask

  // Random part of one phase: clustered insert/query bursts plus noise
  task automatic random_phase(int n_items);
    int done, burst;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        send(mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                $urandom));
        done++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send(mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
          done++;
        end
        burst = $urandom_range(2, 10);
        repeat (burst) begin
          send(mk(MODE_INSERT, near(3), near(3), near(4), near(4),
                  $urandom_range(ONE / 4, 2 * ONE)));
          done++;
        end
        repeat ($urandom_range(1, 4)) begin
          send(mk(MODE_QUERY, near(3), near(3), near(4), near(4),
                  $urandom_range(ONE / 4, 2 * ONE)));
          done++;
        end
      end
    end
  endtask

  initial begin
    sent_cnt  = 0;
    cfg_cnt   = 0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_CELL_SCALE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: contacts, too-close pair, extremes, undefined mode, full bucket
    send(mk(MODE_INSERT, 0, 0, 0, 0, ONE));
    send(mk(MODE_INSERT, ONE + ONE / 2, 0, ONE, 0, ONE));
    send(mk(MODE_QUERY, ONE / 2, 0, 0, ONE, ONE));
    send(mk(MODE_QUERY, 0, 0, 0, 0, ONE));
    send(mk(MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF));
    send(mk(MODE_QUERY, 32'h7FFF_F000, 32'h8000_1000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF));
    send(mk(MODE_UNDEF, '1, '1, '1, '1, '1));
    repeat (9) send(mk(MODE_INSERT, 5 * ONE + 100, 5 * ONE, 0, 0, ONE));
    send(mk(MODE_QUERY, 5 * ONE, 5 * ONE + ONE / 2, 0, 0, ONE));
    send(mk(MODE_CLEAR, 0, 0, 0, 0, 0));
    send(mk(MODE_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF));

    // Aliased cells under the largest scale
    configure(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(mk(MODE_INSERT, 0, 0, ONE, ONE, ONE));
    send(mk(MODE_QUERY, 32'h0100_0100, 0, 0, 0, 32'h7FFF_FFFF));
    send(mk(MODE_QUERY, ONE / 8, 0, 32'h8000_0000, 0, ONE));
    random_phase(40);

    // Long receiver hold while the sender keeps offering words
    hold_req = 1'b1;
    random_phase(10);

    configure(CELL_SCALE_RST, SPRING_K_RST, DAMPING_RST);
    random_phase(50);
    configure(16'd0, 32'd0, 32'd0);
    random_phase(30);
    configure(16'd256, 32'd131072, 32'd32768);
    random_phase(50);
    configure(16'($urandom_range(64, 512)), $urandom, $urandom_range(0, 4 * ONE));
    random_phase(40);

    // Drain and let the last result settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d words of insert, query, clear and undefined mode", sent_cnt);
    $display("over %0d register settings plus reset values", cfg_cnt);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/gcf_pkg.sv
hdl/grid_binned_contact_force.sv
dv/gcf_checker.sv
dv/testbench.sv
